### hw/rtl/keyed_lfsr_byte_scrambler_assert.svh
// Assertion macros for the keyed LFSR byte scrambler.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef KEYED_LFSR_BYTE_SCRAMBLER_ASSERT_SVH
`define KEYED_LFSR_BYTE_SCRAMBLER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define KLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scrambler check failed");

// Next-cycle implication, gated off during reset.
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scrambler check failed");

`endif

### hw/rtl/kls_pkg.sv
// Shared constants and types for the keyed LFSR byte scrambler.
// No dependencies; imported by the interfaces and the top level.
package kls_pkg;

    localparam int KEY_BYTES_MAX = 16;   // default and upper limit of key length
    localparam int DATA_W        = 8;
    localparam int TAP_W         = 64;
    localparam int KEYLEN_W      = 5;
    localparam int CFG_IDX_W     = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Register indexes of the configuration port
    localparam t_cfg_index CFG_TAP_LO    = 2'd0;
    localparam t_cfg_index CFG_TAP_HI    = 2'd1;
    localparam t_cfg_index CFG_KEY_BYTES = 2'd2;

endpackage

### hw/rtl/kls_if.sv
// Valid/ready channel interfaces of the keyed LFSR byte scrambler.
// Depends on kls_pkg for field widths.
interface kls_data_if import kls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface kls_result_if import kls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_byte;
    logic              key_error;

    modport source (output valid, output out_byte, output key_error, input ready);
    modport sink   (input valid, input out_byte, input key_error, output ready);
endinterface

interface kls_cfg_if import kls_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_index       index;
    logic [TAP_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/keyed_lfsr_byte_scrambler.sv
// Keyed LFSR byte scrambler, top level.
// Depends on kls_pkg, the channel interfaces in kls_if.sv and the assertion macros.
//
// Additive Fibonacci scrambler: every data word is XORed with one 8-bit block of an
// LFSR of 8 * key_bytes bits (all ones after reset or any listed register write).
// Taps are the set bits of {tap_mask_high, tap_mask_low} below the live length. The
// block pointer walks the register; at the start or past the last live block the
// LFSR steps once (tap parity enters at bit 0) and block 0 is used. Register bit
// 8k+j lands on result bit 7-j. An odd live tap count flags key_error, passes the
// word unchanged and freezes the LFSR. Throughput is one word per clock while the
// output is not stalled. A taken word sits in the input register, then the tap
// parity, feedback step and block select run in one combinational pass into the
// result register, which it loads once that register is free or emptying.
// While a result waits, the input register takes one more word and then holds off
// until the result leaves. key_bytes of zero acts as one; values above MAX_KEY_BYTES
// act as MAX_KEY_BYTES. The configuration port is always ready; write registers
// only while the block is idle.
`include "keyed_lfsr_byte_scrambler_assert.svh"

module keyed_lfsr_byte_scrambler
    import kls_pkg::*;
#(
    parameter int MAX_KEY_BYTES = KEY_BYTES_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    kls_cfg_if.sink             i_cfg,
    kls_data_if.sink            i_in,
    kls_result_if.source        o_out
);

    localparam int LFSR_W = 8 * MAX_KEY_BYTES;
    localparam int PTR_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int BLK_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // Configuration registers
    logic [TAP_W-1:0]    r_tap_lo;
    logic [TAP_W-1:0]    r_tap_hi;
    logic [KEYLEN_W-1:0] r_key_bytes;

    // Scrambler state
    logic [LFSR_W-1:0]   r_lfsr;
    logic [PTR_W-1:0]    r_ptr;

    // Input register and result register
    logic                r_s1_valid;
    logic [DATA_W-1:0]   r_s1_data;
    logic                r_o_valid;
    logic [DATA_W-1:0]   r_o_byte;
    logic                r_o_key_error;

    logic                cfg_we;
    logic                cfg_listed;
    logic                in_take;
    logic                advance;
    logic [PTR_W-1:0]    live_bytes;
    logic [LFSR_W-1:0]   live_mask;
    logic [LFSR_W-1:0]   live_taps;
    logic [2*TAP_W-1:0]  tap_cat;
    logic                key_err;
    logic                wrap;
    logic                fb;
    logic [PTR_W-1:0]    blk_idx;
    logic [LFSR_W-1:0]   n_lfsr;
    logic [PTR_W-1:0]    n_ptr;
    logic [7:0]          blocks [MAX_KEY_BYTES];
    logic [7:0]          raw_blk;
    logic [DATA_W-1:0]   key_word;
    logic [DATA_W-1:0]   n_o_byte;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;
    assign cfg_listed  = cfg_we && ((i_cfg.index == CFG_TAP_LO) ||
                                    (i_cfg.index == CFG_TAP_HI) ||
                                    (i_cfg.index == CFG_KEY_BYTES));

    // Move the held word into the result register when that slot frees up
    assign advance    = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------------
    // Live length and taps
    // ---------------------------------------------------------------------
    always_comb begin
        // Clamp key length into 1..MAX_KEY_BYTES
        if (r_key_bytes == '0) begin
            live_bytes = PTR_W'(1);
        end else if (r_key_bytes > KEYLEN_W'(MAX_KEY_BYTES)) begin
            live_bytes = PTR_W'(MAX_KEY_BYTES);
        end else begin
            live_bytes = r_key_bytes[PTR_W-1:0];
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            live_mask[8*b +: 8] = (PTR_W'(b) < live_bytes) ? 8'hFF : 8'h00;
        end
    end

    assign tap_cat   = {r_tap_hi, r_tap_lo};
    assign live_taps = tap_cat[LFSR_W-1:0] & live_mask;
    assign key_err   = ^live_taps;

    // ---------------------------------------------------------------------
    // LFSR step and block select
    // ---------------------------------------------------------------------
    // Step at the start of the register or once the pointer runs past the live blocks
    assign wrap    = (r_ptr == '0) || (r_ptr >= live_bytes);
    assign fb      = ^(r_lfsr & live_taps);
    assign blk_idx = wrap ? '0 : r_ptr;
    assign n_ptr   = blk_idx + PTR_W'(1);

    always_comb begin
        if (wrap) begin
            n_lfsr = {r_lfsr[LFSR_W-2:0], fb};
        end else begin
            n_lfsr = r_lfsr;
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            blocks[b] = n_lfsr[8*b +: 8];
        end
    end

    assign raw_blk = blocks[blk_idx[BLK_W-1:0]];

    // Register bit 8k+j feeds result bit 7-j
    always_comb begin
        for (int j = 0; j < DATA_W; j++) begin
            key_word[DATA_W-1-j] = raw_blk[j];
        end
    end

    assign n_o_byte = key_err ? r_s1_data : (r_s1_data ^ key_word);

    // ---------------------------------------------------------------------
    // Configuration and state registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_lo    <= '0;
            r_tap_hi    <= '0;
            r_key_bytes <= KEYLEN_W'(1);
            r_lfsr      <= '1;
            r_ptr       <= '0;
        end else if (cfg_we) begin
            // Any listed register write reloads the LFSR and the pointer
            unique case (i_cfg.index)
                CFG_TAP_LO: begin
                    r_tap_lo <= i_cfg.data;
                    r_lfsr   <= '1;
                    r_ptr    <= '0;
                end
                CFG_TAP_HI: begin
                    r_tap_hi <= i_cfg.data;
                    r_lfsr   <= '1;
                    r_ptr    <= '0;
                end
                CFG_KEY_BYTES: begin
                    r_key_bytes <= i_cfg.data[KEYLEN_W-1:0];
                    r_lfsr      <= '1;
                    r_ptr       <= '0;
                end
                default: begin
                    // Unlisted index: drop the write
                end
            endcase
        end else if (advance && !key_err) begin
            r_lfsr <= n_lfsr;
            r_ptr  <= n_ptr;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in.data_byte;
        end
        if (advance) begin
            r_o_byte      <= n_o_byte;
            r_o_key_error <= key_err;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.out_byte  = r_o_byte;
    assign o_out.key_error = r_o_key_error;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // Pointer never runs past the live block count
    `KLS_ASSERT_NOW(a_ptr_in_range, i_clk, i_rst_n, 1'b1, r_ptr <= live_bytes)
    // A listed register write restarts the pointer
    `KLS_ASSERT_NEXT(a_cfg_reload, i_clk, i_rst_n, cfg_listed, r_ptr == '0)
    // A bad key leaves the LFSR frozen
    `KLS_ASSERT_NEXT(a_err_hold, i_clk, i_rst_n, advance && key_err && !cfg_we, $stable(r_lfsr))
    // A wrap consumes block 0 and parks the pointer on block 1
    `KLS_ASSERT_NEXT(a_wrap_ptr, i_clk, i_rst_n, advance && !key_err && wrap && !cfg_we, r_ptr == PTR_W'(1))

endmodule

### tb/keyed_lfsr_byte_scrambler_tb.sv
// Self-checking testbench for the keyed LFSR byte scrambler: directed table, then random words.
// Depends on kls_pkg, the channel interfaces in kls_if.sv and the keyed_lfsr_byte_scrambler RTL.
module keyed_lfsr_byte_scrambler_tb;
    import kls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int  NUM_SEGMENTS      = 24;
    localparam int  WORDS_PER_SEGMENT = 76;
    localparam int  DRAIN_CYCLES      = 4;      // margin after the input and result registers empty
    localparam int  MAX_REPORTS       = 10;
    localparam longint CYCLE_LIMIT    = 400000;

    // Index past the register list: a write there must change nothing
    localparam t_cfg_index CFG_SPARE = 2'd3;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              key_error;
    } t_scramble_word;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_index        index;
        logic [TAP_W-1:0]  value;
        logic [DATA_W-1:0] data_byte;
        logic              known;     // expected word typed into the row
        t_scramble_word    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    kls_cfg_if    cfg_if ();
    kls_data_if   data_if ();
    kls_result_if result_if ();

    keyed_lfsr_byte_scrambler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (data_if),
        .o_out   (result_if)
    );

    // Shadow copy of the scrambler: registers, LFSR and block pointer
    logic [TAP_W-1:0]    tap_lo_q;
    logic [TAP_W-1:0]    tap_hi_q;
    logic [KEYLEN_W-1:0] key_bytes_q;
    logic [127:0]        lfsr_q;
    logic [4:0]          blk_ptr_q;

    t_scramble_word expected_words[$];
    t_stim_row      directed_rows[$];

    int     src_idle_pct;
    int     sink_stall_pct;
    int     mismatch_count = 0;
    longint cycle_count = 0;

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyed_lfsr_byte_scrambler_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Zero acts as one byte, anything above the limit acts as the limit.
    function automatic int live_key_bytes(input logic [KEYLEN_W-1:0] kb);
        int n;
        n = (kb == 0) ? 1 : int'(kb);
        if (n > KEY_BYTES_MAX) n = KEY_BYTES_MAX;
        return n;
    endfunction

    // Drop mask bits at or above the live register length.
    function automatic logic [127:0] live_taps(input logic [TAP_W-1:0] lo,
                                               input logic [TAP_W-1:0] hi,
                                               input logic [KEYLEN_W-1:0] kb);
        int           len;
        logic [127:0] span;
        len  = 8 * live_key_bytes(kb);
        span = (len >= 128) ? '1 : ((128'd1 << len) - 128'd1);
        return {hi, lo} & span;
    endfunction

    task automatic reload_lfsr();
        lfsr_q    = '1;
        blk_ptr_q = '0;
    endtask

    task automatic apply_register(input t_cfg_index idx, input logic [TAP_W-1:0] value);
        case (idx)
            CFG_TAP_LO:    tap_lo_q    = value;
            CFG_TAP_HI:    tap_hi_q    = value;
            CFG_KEY_BYTES: key_bytes_q = value[KEYLEN_W-1:0];
            default:       return;
        endcase
        reload_lfsr();
    endtask

    // Scramble one word and advance the shadow LFSR and pointer.
    function automatic t_scramble_word predict_scramble(input logic [DATA_W-1:0] d);
        t_scramble_word w;
        logic [127:0]   taps;
        logic [7:0]     blk;
        int             n;
        int             k;
        taps = live_taps(tap_lo_q, tap_hi_q, key_bytes_q);
        n    = live_key_bytes(key_bytes_q);
        if (^taps) begin
            // odd tap count: pass the word through, freeze the LFSR
            w.out_byte  = d;
            w.key_error = 1'b1;
        end else begin
            if (blk_ptr_q == 0 || int'(blk_ptr_q) >= n) begin
                lfsr_q = {lfsr_q[126:0], ^(lfsr_q & taps)};
                k      = 0;
            end else begin
                k = int'(blk_ptr_q);
            end
            blk_ptr_q = 5'(k + 1);
            blk       = lfsr_q[8*k +: 8];
            // register bit 8k+j lands on word bit 7-j
            for (int j = 0; j < 8; j++) w.out_byte[7-j] = d[7-j] ^ blk[j];
            w.key_error = 1'b0;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving helpers (all entered and left at a falling edge)
    // ------------------------------------------------------------------

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 83; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 83; end
            default:       begin src_idle_pct = 37; sink_stall_pct = 37; end
        endcase
    endtask

    // Hold until every expected word has come back.
    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [TAP_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_register(idx, value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_word(input logic [DATA_W-1:0] d, input logic known,
                             input t_scramble_word want);
        t_scramble_word w;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            data_if.valid = 1'b0;
            @(negedge i_clk);
        end
        data_if.valid     = 1'b1;
        data_if.data_byte = d;
        do @(posedge i_clk); while (!data_if.ready);
        // accepted: advance the shadow model in acceptance order
        w = predict_scramble(d);
        expected_words.insert(expected_words.size(), known ? want : w);
        @(negedge i_clk);
        data_if.valid = 1'b0;
    endtask

    task automatic add_cfg_row(input t_cfg_index idx, input logic [TAP_W-1:0] value);
        t_stim_row row;
        row = '{ROW_CFG, idx, value, 8'h00, 1'b0, '0};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic add_word_row(input logic [DATA_W-1:0] d, input logic known,
                                input logic [DATA_W-1:0] out_b, input logic err);
        t_stim_row row;
        row = '{ROW_WORD, CFG_TAP_LO, '0, d, known, '{out_b, err}};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, checker on every accepted result word
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        result_if.ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_scramble_word want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: out_byte %02h key_error %0d",
                             result_if.out_byte, result_if.key_error);
            end else begin
                want = expected_words.pop_front();
                if (result_if.out_byte !== want.out_byte ||
                    result_if.key_error !== want.key_error) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected out_byte %02h key_error %0d, got %02h %0d",
                                 want.out_byte, want.key_error,
                                 result_if.out_byte, result_if.key_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_cfg_index          reg_order[3];
        logic [TAP_W-1:0]    new_lo;
        logic [TAP_W-1:0]    new_hi;
        logic [KEYLEN_W-1:0] new_kb;
        logic [DATA_W-1:0]   d;
        int                  start;
        t_idle_mode          mode;

        // Known values on every input from time zero
        i_rst_n             = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_TAP_LO;
        cfg_if.data         = '0;
        data_if.valid       = 1'b0;
        data_if.data_byte   = '0;
        reg_order           = '{CFG_TAP_LO, CFG_TAP_HI, CFG_KEY_BYTES};
        set_idling(IDLE_NONE);

        tap_lo_q    = '0;
        tap_hi_q    = '0;
        key_bytes_q = 5'd1;
        reload_lfsr();

        // Directed table. After reset: one key byte, no taps, feedback zero,
        // so the low byte walks FE, FC, F8 and reads back bit-reversed.
        add_word_row(8'h00, 1'b1, 8'h7F, 1'b0);
        add_word_row(8'hFF, 1'b1, 8'hC0, 1'b0);
        // write past the register list: no reload, stream continues
        add_cfg_row(CFG_SPARE, '1);
        add_word_row(8'h00, 1'b1, 8'h1F, 1'b0);
        // single tap: odd count, words pass through flagged
        add_cfg_row(CFG_TAP_LO, 64'h1);
        add_word_row(8'hA5, 1'b1, 8'hA5, 1'b1);
        add_word_row(8'h5A, 1'b1, 8'h5A, 1'b1);
        add_word_row(8'hFF, 1'b1, 8'hFF, 1'b1);
        // two taps inside one byte
        add_cfg_row(CFG_TAP_LO, 64'h81);
        add_word_row(8'h00, 1'b0, '0, 1'b0);
        add_word_row(8'hFF, 1'b0, '0, 1'b0);
        add_word_row(8'h3C, 1'b0, '0, 1'b0);
        // two key bytes: pointer walks block 0, block 1, then wraps
        add_cfg_row(CFG_KEY_BYTES, 64'd2);
        for (int i = 0; i < 5; i++) add_word_row(8'(8'h11 * i), 1'b0, '0, 1'b0);
        // zero key length acts as one byte
        add_cfg_row(CFG_KEY_BYTES, 64'd0);
        add_cfg_row(CFG_TAP_LO, 64'h3);
        add_word_row(8'h80, 1'b0, '0, 1'b0);
        add_word_row(8'h01, 1'b0, '0, 1'b0);
        // key length above the limit clamps to 128 bits: top tap alone is odd
        add_cfg_row(CFG_TAP_LO, 64'h0);
        add_cfg_row(CFG_TAP_HI, 64'h8000_0000_0000_0000);
        add_cfg_row(CFG_KEY_BYTES, 64'd31);
        add_word_row(8'h81, 1'b1, 8'h81, 1'b1);
        // 64-bit register: the top tap lies beyond it and is ignored
        add_cfg_row(CFG_KEY_BYTES, 64'd8);
        add_word_row(8'hFF, 1'b1, 8'h80, 1'b0);
        // every tap set, full length: 128 taps, even
        add_cfg_row(CFG_TAP_LO, '1);
        add_cfg_row(CFG_TAP_HI, '1);
        add_cfg_row(CFG_KEY_BYTES, 64'd16);
        for (int i = 0; i < 3; i++) add_word_row(8'(8'h96 ^ i), 1'b0, '0, 1'b0);

        // Reset held from time zero, released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_register(directed_rows[i].index, directed_rows[i].value);
            else
                send_word(directed_rows[i].data_byte, directed_rows[i].known,
                          directed_rows[i].want);
        end

        // Random segments: new key, then a stream of words under one idling mode
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            mode = t_idle_mode'(seg % 4);

            if (seg == 0 || $urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 5))
                    0:       new_kb = 5'd1;
                    1:       new_kb = 5'd16;
                    2:       new_kb = 5'($urandom_range(17, 31));
                    3:       new_kb = 5'd0;
                    default: new_kb = 5'($urandom_range(1, 16));
                endcase
                case ($urandom_range(0, 9))
                    0:       begin new_lo = '1; new_hi = '1; end
                    1:       begin new_lo = '0; new_hi = '0; end
                    default: begin
                        new_lo = {$urandom, $urandom};
                        new_hi = {$urandom, $urandom};
                    end
                endcase
                // mostly keep the live tap count even so the LFSR actually runs;
                // bit 0 is always inside the register
                if ($urandom_range(0, 9) < 8 && ^live_taps(new_lo, new_hi, new_kb))
                    new_lo[0] = ~new_lo[0];

                start = $urandom_range(0, 2);
                for (int r = 0; r < 3; r++) begin
                    case (reg_order[(start + r) % 3])
                        CFG_TAP_LO:    write_register(CFG_TAP_LO, new_lo);
                        CFG_TAP_HI:    write_register(CFG_TAP_HI, new_hi);
                        default:       write_register(CFG_KEY_BYTES, 64'(new_kb));
                    endcase
                end
                if ($urandom_range(0, 6) == 0)
                    write_register(CFG_SPARE, {$urandom, $urandom});
            end

            set_idling(mode);
            for (int i = 0; i < WORDS_PER_SEGMENT; i++) begin
                // drain completely mid-stream now and then
                if (mode == IDLE_NONE && i == WORDS_PER_SEGMENT / 2) wait_drained();
                case ($urandom_range(0, 19))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                send_word(d, 1'b0, '0);
            end
        end

        // Let the pipeline empty, then wait on for stray words
        set_idling(IDLE_NONE);
        wait_drained();
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("keyed_lfsr_byte_scrambler_tb passed");
        end else begin
            $display("keyed_lfsr_byte_scrambler_tb failed");
        end
        $finish;
    end

endmodule
